/* rtl/lkvc_pkg.sv */
// lkvc_pkg: shared constants for the LRU key-value cache.
// No dependencies; used by lru_key_value_cache, lkvc_checker and tb_top.
package lkvc_pkg;

   // default sizes
   localparam int CAPACITY_DEF   = 16;
   localparam int KEY_BITS_DEF   = 16;
   localparam int VALUE_BITS_DEF = 32;

   // capacity register
   localparam int              CFG_W       = 5;
   localparam logic [CFG_W-1:0] CAP_RESET  = 5'd16;

   // csr port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_CAPACITY = 1'b0;

   // operation codes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

endpackage

/* rtl/lru_key_value_cache.sv */
// lru_key_value_cache: fully associative key-value cache with LRU replacement.
// Depends on lkvc_pkg (sizes, register layout, op codes).
//
//  channel   ports                                      handshake
//  -------   -----------------------------------------  ---------------------------
//  request   req_op, req_key, req_value                 start & !busy
//  result    rsp_hit, rsp_read_value, rsp_evicted,      rsp_valid strobe, one cycle
//            rsp_evicted_key
//  csr       psel, penable, pwrite, paddr, pwdata,      APB write on access phase
//            prdata, pready
//
// One item per cycle. An accepted item is held in the request register, looked
// up and applied to the entry registers, and its beat is shown on the rsp_
// ports from the result register. The rate is set by the parallel key compare
// and rank update across all entry registers. busy never rises.
// Reset clears all entries and sets the capacity to 16.
// The receiver cannot stall; every result beat is taken when shown.
module lru_key_value_cache #(
   parameter int CAPACITY   = lkvc_pkg::CAPACITY_DEF,
   parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_op,
   input  logic [KEY_BITS-1:0]             req_key,
   input  logic [VALUE_BITS-1:0]           req_value,
   // result
   output logic                            rsp_valid,
   output logic                            rsp_hit,
   output logic [VALUE_BITS-1:0]           rsp_read_value,
   output logic                            rsp_evicted,
   output logic [KEY_BITS-1:0]             rsp_evicted_key,
   // csr
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lkvc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lkvc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lkvc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   localparam int RANK_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CFG_W  = lkvc_pkg::CFG_W;
   localparam int CW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   // csr
   logic [CFG_W-1:0] cap_ff;
   logic             csr_wr;

   // request register
   logic                  req_valid_ff;
   logic                  req_op_ff;
   logic [KEY_BITS-1:0]   req_key_ff;
   logic [VALUE_BITS-1:0] req_value_ff;

   // entry registers
   logic [KEY_BITS-1:0]   key_ff   [CAPACITY];
   logic [VALUE_BITS-1:0] value_ff [CAPACITY];
   logic [RANK_W-1:0]     rank_ff  [CAPACITY];
   logic [RANK_W-1:0]     rank_in  [CAPACITY];
   logic [CAPACITY-1:0]   valid_ff;
   logic [CAPACITY-1:0]   valid_in;
   logic [CAPACITY-1:0]   key_we;
   logic [CAPACITY-1:0]   value_we;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff,     rsp_hit_in;
   logic [VALUE_BITS-1:0] rsp_value_ff,   rsp_value_in;
   logic                  rsp_evicted_ff, rsp_evicted_in;
   logic [KEY_BITS-1:0]   rsp_evkey_ff,   rsp_evkey_in;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      prdata = '0;
      if (paddr[2] == lkvc_pkg::CSR_IDX_CAPACITY) begin
         prdata = lkvc_pkg::CSR_DATA_W'(cap_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkvc_pkg::CAP_RESET;
      end else if (csr_wr && paddr[2] == lkvc_pkg::CSR_IDX_CAPACITY) begin
         cap_ff <= pwdata[CFG_W-1:0];
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         req_op_ff    <= req_op;
         req_key_ff   <= req_key;
         req_value_ff <= req_value;
      end
   end

   // lookup and update
   always_comb begin
      logic [CW-1:0]         eff_cap;
      logic [CW-1:0]         count_ext;
      logic [CNT_W-1:0]      count_dec;
      logic [RANK_W-1:0]     last_rank;
      logic [CAPACITY-1:0]   match;
      logic [CAPACITY-1:0]   old_pre;
      logic [CAPACITY-1:0]   old_post;
      logic [CAPACITY-1:0]   ev_sel;
      logic [CAPACITY-1:0]   valid_mid;
      logic [CAPACITY-1:0]   free_sel;
      logic [RANK_W-1:0]     rank_t [CAPACITY];
      logic [RANK_W-1:0]     hit_rank;
      logic [VALUE_BITS-1:0] hit_value;
      logic                  hit;
      logic                  is_put;
      logic                  do_evict;
      logic                  found;

      if (cap_ff == '0) begin
         eff_cap = CW'(1);
      end else if (CW'(cap_ff) > CW'(CAPACITY)) begin
         eff_cap = CW'(CAPACITY);
      end else begin
         eff_cap = CW'(cap_ff);
      end
      count_ext = CW'(count_ff);
      count_dec = count_ff - CNT_W'(1);
      last_rank = count_dec[RANK_W-1:0];
      is_put    = (req_op_ff == lkvc_pkg::OP_PUT);

      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match[i]  = valid_ff[i] && (key_ff[i] == req_key_ff);
         hit_rank  = hit_rank | (rank_ff[i] & {RANK_W{match[i]}});
         hit_value = hit_value | (value_ff[i] & {VALUE_BITS{match[i]}});
      end
      hit = |match;

      // ranks after making the hit entry most recent
      for (int i = 0; i < CAPACITY; i++) begin
         if (match[i]) begin
            rank_t[i] = '0;
         end else if (valid_ff[i] && rank_ff[i] < hit_rank) begin
            rank_t[i] = rank_ff[i] + RANK_W'(1);
         end else begin
            rank_t[i] = rank_ff[i];
         end
         old_pre[i]  = valid_ff[i] && (rank_ff[i] == last_rank);
         old_post[i] = valid_ff[i] && (rank_t[i] == last_rank);
      end

      if (hit) begin
         do_evict = is_put && (count_ext > eff_cap);
         ev_sel   = do_evict ? old_post : '0;
      end else begin
         do_evict = is_put && (count_ext >= eff_cap);
         ev_sel   = do_evict ? old_pre : '0;
      end
      valid_mid = valid_ff & ~ev_sel;

      // first free slot after any eviction
      found    = 1'b0;
      free_sel = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (!valid_mid[i] && !found) begin
            free_sel[i] = 1'b1;
            found       = 1'b1;
         end
      end

      rsp_evkey_in = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rsp_evkey_in = rsp_evkey_in | (key_ff[i] & {KEY_BITS{ev_sel[i]}});
      end
      rsp_evicted_in = do_evict;
      rsp_hit_in     = hit;
      rsp_value_in   = (hit && !is_put) ? hit_value : '0;

      valid_in = valid_ff;
      count_in = count_ff;
      key_we   = '0;
      value_we = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rank_in[i] = rank_ff[i];
      end

      if (req_valid_ff) begin
         if (hit) begin
            for (int i = 0; i < CAPACITY; i++) begin
               rank_in[i] = rank_t[i];
            end
            valid_in = valid_mid;
            value_we = is_put ? match : '0;
            if (do_evict) begin
               count_in = count_dec;
            end
         end else if (is_put) begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (free_sel[i]) begin
                  rank_in[i] = '0;
               end else if (valid_mid[i]) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
            valid_in = valid_mid | free_sel;
            key_we   = free_sel;
            value_we = free_sel;
            if (!do_evict) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (key_we[i]) begin
            key_ff[i] <= req_key_ff;
         end
         if (value_we[i]) begin
            value_ff[i] <= req_value_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_hit_ff     <= rsp_hit_in;
         rsp_value_ff   <= rsp_value_in;
         rsp_evicted_ff <= rsp_evicted_in;
         rsp_evkey_ff   <= rsp_evkey_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evkey_ff;

endmodule

/* dv/lkvc_checker.sv */
// lkvc_checker: watches the request, result and csr beats of the LRU cache,
// keeps its own copy of the entries and checks every result beat in order.
// Depends on lkvc_pkg (sizes, op codes, csr layout).
module lkvc_checker #(
   parameter int CAPACITY   = lkvc_pkg::CAPACITY_DEF,
   parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic                            req_op,
   input  logic [KEY_BITS-1:0]             req_key,
   input  logic [VALUE_BITS-1:0]           req_value,
   input  logic                            rsp_valid,
   input  logic                            rsp_hit,
   input  logic [VALUE_BITS-1:0]           rsp_read_value,
   input  logic                            rsp_evicted,
   input  logic [KEY_BITS-1:0]             rsp_evicted_key,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lkvc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lkvc_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [lkvc_pkg::CSR_DATA_W-1:0] prdata,
   input  logic                            pready,
   output int                              fail_count,
   output int                              in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [lkvc_pkg::CSR_ADDR_W-1:0] CAP_ADDR = {lkvc_pkg::CSR_IDX_CAPACITY, 2'b00};

   typedef struct {
      logic                  hit;
      logic [VALUE_BITS-1:0] read_value;
      logic                  evicted;
      logic [KEY_BITS-1:0]   evicted_key;
   } access_result_type;

   access_result_type due_results[$];

   logic [KEY_BITS-1:0]        slot_key[CAPACITY];
   logic [VALUE_BITS-1:0]      slot_value[CAPACITY];
   bit                         slot_valid[CAPACITY];
   int unsigned                slot_age[CAPACITY];   // 0 = most recent
   int unsigned                held_count;
   logic [lkvc_pkg::CFG_W-1:0] capacity_reg;
   int                         errors = 0;

   function automatic int unsigned room();
      if (capacity_reg == '0) return 1;
      if (capacity_reg > CAPACITY) return CAPACITY;
      return 32'(capacity_reg);
   endfunction

   task automatic promote(input int s);
      int unsigned r;
      r = slot_age[s];
      for (int i = 0; i < CAPACITY; i++)
         if (slot_valid[i] && slot_age[i] < r) slot_age[i]++;
      slot_age[s] = 0;
   endtask

   task automatic evict_lru(output logic [KEY_BITS-1:0] k);
      int best;
      bit found;
      best  = 0;
      found = 1'b0;
      k     = '0;
      for (int i = 0; i < CAPACITY; i++)
         if (slot_valid[i] && (!found || slot_age[i] > slot_age[best])) begin
            best  = i;
            found = 1'b1;
         end
      if (found) begin
         slot_valid[best] = 1'b0;
         if (held_count > 0) held_count--;
         k = slot_key[best];
      end
   endtask

   task automatic cache_access(input logic op, input logic [KEY_BITS-1:0] key,
                               input logic [VALUE_BITS-1:0] value,
                               output access_result_type res);
      int slot;
      bit found;
      int free_slot;
      bit has_free;
      res.hit         = 1'b0;
      res.read_value  = '0;
      res.evicted     = 1'b0;
      res.evicted_key = '0;
      slot  = 0;
      found = 1'b0;
      for (int i = 0; i < CAPACITY; i++)
         if (!found && slot_valid[i] && slot_key[i] == key) begin
            slot  = i;
            found = 1'b1;
         end
      res.hit = found;
      if (op == lkvc_pkg::OP_GET) begin
         if (found) begin
            promote(slot);
            res.read_value = slot_value[slot];
         end
      end else if (found) begin
         slot_value[slot] = value;
         promote(slot);
         // capacity lowered below count: each put sheds one entry
         if (held_count > room()) begin
            evict_lru(res.evicted_key);
            res.evicted = 1'b1;
         end
      end else begin
         if (held_count >= room()) begin
            evict_lru(res.evicted_key);
            res.evicted = 1'b1;
         end
         free_slot = 0;
         has_free  = 1'b0;
         for (int i = 0; i < CAPACITY; i++)
            if (!has_free && !slot_valid[i]) begin
               free_slot = i;
               has_free  = 1'b1;
            end
         if (has_free) begin
            for (int i = 0; i < CAPACITY; i++)
               if (slot_valid[i]) slot_age[i]++;
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot]   = key;
            slot_value[free_slot] = value;
            slot_age[free_slot]   = 0;
            held_count++;
         end
      end
   endtask

   task automatic flag(input string msg);
      errors++;
      if (errors <= 10) $display("%t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      access_result_type res;
      access_result_type want;
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) begin
            slot_valid[i] = 1'b0;
            slot_age[i]   = 0;
         end
         held_count   = 0;
         capacity_reg = lkvc_pkg::CAP_RESET;
         due_results.delete();
      end else begin
         if (psel && penable && pready && paddr == CAP_ADDR) begin
            if (pwrite) begin
               capacity_reg = pwdata[lkvc_pkg::CFG_W-1:0];
            end else if (prdata !== lkvc_pkg::CSR_DATA_W'(capacity_reg)) begin
               flag($sformatf("capacity readback exp %0d got %0d", capacity_reg, prdata));
            end
         end
         if (start && !busy) begin
            cache_access(req_op, req_key, req_value, res);
            due_results.insert(due_results.size(), res);
         end
         if (rsp_valid) begin
            if (due_results.size() == 0) begin
               flag("result beat with no request outstanding");
            end else begin
               want = due_results[0];
               due_results.delete(0);
               if (rsp_hit !== want.hit || rsp_read_value !== want.read_value ||
                   rsp_evicted !== want.evicted || rsp_evicted_key !== want.evicted_key) begin
                  flag($sformatf({"result mismatch: exp hit %0b value %h evicted %0b key %h,",
                                  " got hit %0b value %h evicted %0b key %h"},
                                 want.hit, want.read_value, want.evicted, want.evicted_key,
                                 rsp_hit, rsp_read_value, rsp_evicted, rsp_evicted_key));
               end
            end
         end
      end
      in_flight  <= due_results.size();
      fail_count <= errors;
   end

endmodule

/* dv/tb_top.sv */
// tb_top: drives get/put beats and capacity writes into lru_key_value_cache.
// Depends on lkvc_pkg, lru_key_value_cache and lkvc_checker (which does the checking).
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KW             = lkvc_pkg::KEY_BITS_DEF;
   localparam int VW             = lkvc_pkg::VALUE_BITS_DEF;
   localparam int DW             = lkvc_pkg::CSR_DATA_W;
   localparam int RANDOM_ITEMS   = 1250;
   localparam int PHASES         = 12;
   localparam int POOL_MAX       = 24;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam logic [lkvc_pkg::CSR_ADDR_W-1:0] CAP_ADDR = {lkvc_pkg::CSR_IDX_CAPACITY, 2'b00};
   // -1 picks a random capacity; 0 and values above 16 are out of range on purpose
   localparam int PHASE_CAP[PHASES] = '{16, 3, 1, 0, 16, 31, 8, 2, 17, 5, -1, -1};

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic                            req_op = lkvc_pkg::OP_GET;
   logic [KW-1:0]                   req_key = '0;
   logic [VW-1:0]                   req_value = '0;
   logic                            rsp_valid;
   logic                            rsp_hit;
   logic [VW-1:0]                   rsp_read_value;
   logic                            rsp_evicted;
   logic [KW-1:0]                   rsp_evicted_key;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [lkvc_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [DW-1:0]                   pwdata = '0;
   logic [DW-1:0]                   prdata;
   logic                            pready;
   int                              fail_count;
   int                              in_flight;

   int            stall_pct = 31;
   int            sent_random = 0;
   int            idle_cycles = 0;
   logic [KW-1:0] key_pool[POOL_MAX];
   int            pool_n;

   lru_key_value_cache u_top (
      .clock, .reset, .start, .busy, .req_op, .req_key, .req_value,
      .rsp_valid, .rsp_hit, .rsp_read_value, .rsp_evicted, .rsp_evicted_key,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   lkvc_checker u_check (
      .clock, .reset, .start, .busy, .req_op, .req_key, .req_value,
      .rsp_valid, .rsp_hit, .rsp_read_value, .rsp_evicted, .rsp_evicted_key,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .fail_count, .in_flight
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // any accepted beat on any port restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable && pready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // each cycle idles with probability stall_pct percent
   task automatic send_item(input logic op, input logic [KW-1:0] key, input logic [VW-1:0] value);
      while ($urandom_range(0, 99) < stall_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_op    <= op;
      req_key   <= key;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [DW-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= CAP_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // upper data bits are junk; only the low five are kept
   task automatic set_capacity(input logic [lkvc_pkg::CFG_W-1:0] cap);
      settle();
      csr_access(1'b1, ($urandom() & ~DW'(5'h1f)) | DW'(cap));
      csr_access(1'b0, '0);
   endtask

   // mostly keys from a small pool so gets hit and puts update/evict
   task automatic random_phase(input int n);
      logic [KW-1:0] key;
      pool_n = $urandom_range(2, POOL_MAX);
      for (int i = 0; i < POOL_MAX; i++) key_pool[i] = KW'($urandom_range(0, 65535));
      repeat (n) begin
         stall_pct = (sent_random < RANDOM_ITEMS / 3)     ? 31 :
                     (sent_random < 2 * RANDOM_ITEMS / 3) ? 54 : 0;
         key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_n - 1)]
                                            : KW'($urandom_range(0, 65535));
         send_item($urandom_range(0, 1) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET, key, $urandom());
         sent_random++;
         if ($urandom_range(0, 99) == 0) settle();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, '0);   // reset value of the capacity

      // empty store, extremes of key and value, update of a held key
      send_item(lkvc_pkg::OP_GET, 16'h0000, 32'hffff_ffff);
      send_item(lkvc_pkg::OP_PUT, 16'h0000, 32'h0000_0000);
      send_item(lkvc_pkg::OP_PUT, 16'hffff, 32'hffff_ffff);
      send_item(lkvc_pkg::OP_GET, 16'hffff, 32'h0000_0000);
      send_item(lkvc_pkg::OP_GET, 16'h0000, 32'h1234_5678);
      send_item(lkvc_pkg::OP_PUT, 16'h0000, 32'h5a5a_5a5a);
      send_item(lkvc_pkg::OP_GET, 16'h1234, 32'ha5a5_a5a5);
      send_item(lkvc_pkg::OP_PUT, 16'h0001, 32'h0000_0001);
      send_item(lkvc_pkg::OP_PUT, 16'h0002, 32'h0000_0002);
      send_item(lkvc_pkg::OP_PUT, 16'h0003, 32'h0000_0003);

      // capacity lowered below the count: gets keep, each put sheds one
      set_capacity(5'd2);
      send_item(lkvc_pkg::OP_GET, 16'h0000, 32'h0);
      send_item(lkvc_pkg::OP_PUT, 16'hffff, 32'h8000_0000);
      send_item(lkvc_pkg::OP_PUT, 16'h0000, 32'h0000_7fff);
      send_item(lkvc_pkg::OP_PUT, 16'h0007, 32'h0000_0007);

      // zero acts as one
      set_capacity(5'd0);
      send_item(lkvc_pkg::OP_PUT, 16'h0009, 32'h0000_0009);
      send_item(lkvc_pkg::OP_GET, 16'h0009, 32'h0);
      send_item(lkvc_pkg::OP_PUT, 16'h000a, 32'h0000_000a);

      // above the entry count acts as full size
      set_capacity(5'd31);
      send_item(lkvc_pkg::OP_PUT, 16'h8000, 32'hdead_beef);
      send_item(lkvc_pkg::OP_GET, 16'h8000, 32'h0);
      send_item(lkvc_pkg::OP_GET, 16'h000a, 32'h0);

      for (int p = 0; p < PHASES; p++) begin
         set_capacity(PHASE_CAP[p] < 0 ? lkvc_pkg::CFG_W'($urandom_range(0, 31))
                                       : lkvc_pkg::CFG_W'(PHASE_CAP[p]));
         random_phase(RANDOM_ITEMS / PHASES);
      end

      settle();
      if (fail_count == 0 && in_flight == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/lkvc_pkg.sv
rtl/lru_key_value_cache.sv
dv/lkvc_checker.sv
dv/tb_top.sv
